@@ rtl/core/mp3_stream_quick_check_top_defines.svh @@
// Assertion macros used by the checker file mp3sqc_checker.sv.
`ifndef MP3_STREAM_QUICK_CHECK_TOP_DEFINES_SVH
`define MP3_STREAM_QUICK_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define MP3SQC_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define MP3SQC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, always on (for reset behavior).
`define MP3SQC_ASSERT_NEXT_ON(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mp3sqc_pkg.sv @@
package mp3sqc_pkg;

  localparam int SIZE_W    = 40;
  localparam int BYTE_W    = 8;
  localparam int RATE_W    = 9;
  localparam int VERDICT_W = 3;
  localparam int POS_W     = 29;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam int WINDOW_BYTES_DEF = 200;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FILE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VBR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE  = 2'd2;

  localparam logic [SIZE_W-1:0] MAX_FILE_RST = 40'd52428800;
  localparam logic [SIZE_W-1:0] MAX_VBR_RST  = 40'd31457280;
  localparam logic [RATE_W-1:0] MIN_RATE_RST = 9'd64;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_OK        = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_LARGE = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_SHORT = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_HDR   = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_LOW_RATE  = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_LARGE_VBR = 3'd5;

  // byte patterns
  localparam logic [23:0] ID3_MAGIC  = 24'h494433;
  localparam logic [31:0] XING_MAGIC = 32'h58696E67;
  localparam logic [31:0] INFO_MAGIC = 32'h496E666F;
  localparam logic [31:0] VBRI_MAGIC = 32'h56425249;
  localparam logic [31:0] SYNC_MASK  = 32'hFFE00000;

  // positions and window limits
  localparam int ID3_MAGIC_LAST  = 2;
  localparam int ID3_SIZE_LAST   = 9;
  localparam int ID3_HDR_BYTES   = 10;
  localparam int FRAME_HDR_LAST  = 3;
  localparam int TAG_LAST_OFF    = 3;
  localparam int VBRI_LAST_OFF   = 39;
  localparam int VBR_MIN_WINDOW  = 40;

  localparam logic [RATE_W-1:0] RATE_TABLE [2][3][16] = '{
    '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    }
  };

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] file_bytes_total;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [RATE_W-1:0] rate;
  } hdr_info_t;

endpackage

@@ rtl/core/mp3sqc_if.sv @@
interface mp3sqc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [mp3sqc_pkg::SIZE_W-1:0]     file_bytes_total;
  logic [mp3sqc_pkg::BYTE_W-1:0]     data_byte;
  logic                              last_byte;

  modport source (output valid, kind, file_bytes_total, data_byte, last_byte, input ready);
  modport sink   (input valid, kind, file_bytes_total, data_byte, last_byte, output ready);
endinterface

interface mp3sqc_out_if;
  logic                              valid;
  logic                              ready;
  logic [mp3sqc_pkg::VERDICT_W-1:0]  verdict;
  logic [mp3sqc_pkg::RATE_W-1:0]     bitrate_kbps;
  logic                              is_vbr;

  modport source (output valid, verdict, bitrate_kbps, is_vbr, input ready);
  modport sink   (input valid, verdict, bitrate_kbps, is_vbr, output ready);
endinterface

@@ rtl/core/mp3sqc_hdr_dec.sv @@
module mp3sqc_hdr_dec (
  input  logic [31:0]           hdr,
  output mp3sqc_pkg::hdr_info_t info
);

  logic [1:0] ver;
  logic [1:0] layer;
  logic [3:0] idx;
  logic [1:0] srate;
  logic [1:0] row;
  logic       tbl;

  assign ver   = hdr[20:19];
  assign layer = hdr[18:17];
  assign idx   = hdr[15:12];
  assign srate = hdr[11:10];
  assign tbl   = (ver != 2'd3);
  assign row   = 2'd3 - layer;

  always_comb begin
    info.ok = ((hdr & mp3sqc_pkg::SYNC_MASK) == mp3sqc_pkg::SYNC_MASK) &&
              (ver != 2'd1) && (layer != 2'd0) && (idx != 4'hF) && (srate != 2'd3);
    if (layer == 2'd0) begin
      info.rate = '0;
    end else begin
      info.rate = mp3sqc_pkg::RATE_TABLE[tbl][row][idx];
    end
  end

endmodule

@@ rtl/core/mp3_stream_quick_check_top.sv @@
// Each item is captured in the input register; a result it causes is then registered.
// Throughput: one item per cycle while results are taken; an input register and a
// result register each hold one item, and the parse state advances once per item.
// Reset (rst, synchronous, active high): both registers empty, parser idle,
// configuration registers back to their defaults.
module mp3_stream_quick_check_top #(
  parameter int WINDOW_BYTES = mp3sqc_pkg::WINDOW_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mp3sqc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mp3sqc_pkg::CFG_DATA_W-1:0]   cfg_data,
  mp3sqc_in_if.sink                           file_stream,
  mp3sqc_out_if.source                        verdict_stream
);

  localparam int CountW = $clog2(WINDOW_BYTES + 1);
  localparam int SizeW  = mp3sqc_pkg::SIZE_W;
  localparam int PosW   = mp3sqc_pkg::POS_W;
  localparam int RateW  = mp3sqc_pkg::RATE_W;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PREFIX, PH_ID3, PH_HEADER, PH_WINDOW, PH_DONE
  } phase_t;

  // configuration
  logic [SizeW-1:0] max_file_bytes;
  logic [SizeW-1:0] max_vbr_file_bytes;
  logic [RateW-1:0] min_bitrate_kbps;

  // input register
  logic                 s1_valid;
  mp3sqc_pkg::in_item_t s1;
  logic                 adv;
  logic                 fire;

  // parse state
  phase_t            phase, phase_next;
  logic [PosW-1:0]   byte_position, pos_next;
  logic [PosW-1:0]   hdr_pos, hdr_pos_next;
  logic [31:0]       shift_bytes, shift_next;
  logic [SizeW-1:0]  saved_size, size_next;
  logic [CountW-1:0] window_count, wc_next;
  logic              tag_seen, tag_next;
  logic [RateW-1:0]  found_bitrate, fbr_next;

  // result register
  logic                                out_valid;
  logic [mp3sqc_pkg::VERDICT_W-1:0]    out_verdict;
  logic [RateW-1:0]                    out_rate;
  logic                                out_vbr;

  logic                                emit;
  logic [mp3sqc_pkg::VERDICT_W-1:0]    verdict_c;
  logic [RateW-1:0]                    rate_c;
  logic                                vbr_c;
  logic                                finish;
  logic                                short_chk;
  logic                                vbr_found;
  logic [27:0]                         synch_size;

  mp3sqc_pkg::hdr_info_t hdr;

  assign adv  = !out_valid || verdict_stream.ready;
  assign fire = s1_valid && adv;
  assign file_stream.ready = !s1_valid || adv;

  assign synch_size = {shift_next[30:24], shift_next[22:16], shift_next[14:8], shift_next[6:0]};

  mp3sqc_hdr_dec u_hdr_dec (
    .hdr  (shift_next),
    .info (hdr)
  );

  always_comb begin
    phase_next   = phase;
    pos_next     = byte_position;
    hdr_pos_next = hdr_pos;
    shift_next   = shift_bytes;
    size_next    = saved_size;
    wc_next      = window_count;
    tag_next     = tag_seen;
    fbr_next     = found_bitrate;
    emit         = 1'b0;
    verdict_c    = mp3sqc_pkg::VERDICT_OK;
    rate_c       = '0;
    vbr_c        = 1'b0;
    finish       = 1'b0;
    short_chk    = 1'b0;
    vbr_found    = 1'b0;
    if (fire) begin
      if (s1.kind == mp3sqc_pkg::KIND_START) begin
        size_next    = s1.file_bytes_total;
        pos_next     = '0;
        hdr_pos_next = '0;
        shift_next   = '0;
        wc_next      = '0;
        tag_next     = 1'b0;
        fbr_next     = '0;
        phase_next   = PH_PREFIX;
        if (s1.file_bytes_total > max_file_bytes) begin
          emit      = 1'b1;
          verdict_c = mp3sqc_pkg::VERDICT_TOO_LARGE;
        end
      end else if (phase inside {PH_PREFIX, PH_ID3, PH_HEADER, PH_WINDOW}) begin
        shift_next = {shift_bytes[23:0], s1.data_byte};
        if (!(&byte_position)) begin
          pos_next = byte_position + PosW'(1);
        end
        short_chk = 1'b1;
        case (phase)
          PH_PREFIX: begin
            if (byte_position >= PosW'(mp3sqc_pkg::ID3_MAGIC_LAST)) begin
              if (shift_next[23:0] == mp3sqc_pkg::ID3_MAGIC) begin
                phase_next = PH_ID3;
              end else begin
                hdr_pos_next = PosW'(mp3sqc_pkg::FRAME_HDR_LAST);
                phase_next   = PH_HEADER;
              end
            end
          end
          PH_ID3: begin
            if (byte_position >= PosW'(mp3sqc_pkg::ID3_SIZE_LAST)) begin
              hdr_pos_next = PosW'(synch_size) +
                             PosW'(mp3sqc_pkg::ID3_HDR_BYTES + mp3sqc_pkg::FRAME_HDR_LAST);
              phase_next   = PH_HEADER;
            end
          end
          PH_HEADER: begin
            if (byte_position == hdr_pos) begin
              short_chk = 1'b0;
              if (!hdr.ok) begin
                emit      = 1'b1;
                verdict_c = mp3sqc_pkg::VERDICT_BAD_HDR;
              end else begin
                fbr_next = hdr.rate;
                if (hdr.rate != '0 && hdr.rate < min_bitrate_kbps) begin
                  emit      = 1'b1;
                  verdict_c = mp3sqc_pkg::VERDICT_LOW_RATE;
                  rate_c    = hdr.rate;
                end else begin
                  phase_next = PH_WINDOW;
                  finish     = s1.last_byte;
                end
              end
            end
          end
          PH_WINDOW: begin
            short_chk = 1'b0;
            if (window_count >= CountW'(mp3sqc_pkg::TAG_LAST_OFF) &&
                (shift_next == mp3sqc_pkg::XING_MAGIC ||
                 shift_next == mp3sqc_pkg::INFO_MAGIC)) begin
              tag_next = 1'b1;
            end
            if (window_count == CountW'(mp3sqc_pkg::VBRI_LAST_OFF) &&
                shift_next == mp3sqc_pkg::VBRI_MAGIC) begin
              tag_next = 1'b1;
            end
            wc_next = window_count + CountW'(1);
            finish  = s1.last_byte || (wc_next >= CountW'(WINDOW_BYTES));
          end
          default: begin
            short_chk = 1'b0;
          end
        endcase
        if (short_chk && s1.last_byte) begin
          emit      = 1'b1;
          verdict_c = mp3sqc_pkg::VERDICT_TOO_SHORT;
        end
        if (finish) begin
          vbr_found = tag_next && (wc_next >= CountW'(mp3sqc_pkg::VBR_MIN_WINDOW));
          emit      = 1'b1;
          rate_c    = fbr_next;
          vbr_c     = vbr_found;
          if (vbr_found && saved_size > max_vbr_file_bytes) begin
            verdict_c = mp3sqc_pkg::VERDICT_LARGE_VBR;
          end
        end
      end
    end
    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_file_bytes     <= mp3sqc_pkg::MAX_FILE_RST;
      max_vbr_file_bytes <= mp3sqc_pkg::MAX_VBR_RST;
      min_bitrate_kbps   <= mp3sqc_pkg::MIN_RATE_RST;
      s1_valid           <= 1'b0;
      out_valid          <= 1'b0;
      phase              <= PH_IDLE;
      byte_position      <= '0;
      hdr_pos            <= '0;
      shift_bytes        <= '0;
      saved_size         <= '0;
      window_count       <= '0;
      tag_seen           <= 1'b0;
      found_bitrate      <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          mp3sqc_pkg::CFG_MAX_FILE: max_file_bytes     <= cfg_data;
          mp3sqc_pkg::CFG_MAX_VBR:  max_vbr_file_bytes <= cfg_data;
          mp3sqc_pkg::CFG_MIN_RATE: min_bitrate_kbps   <= cfg_data[RateW-1:0];
          default: ;
        endcase
      end
      if (file_stream.ready) begin
        s1_valid <= file_stream.valid;
      end
      if (adv) begin
        out_valid <= fire && emit;
      end
      phase         <= phase_next;
      byte_position <= pos_next;
      hdr_pos       <= hdr_pos_next;
      shift_bytes   <= shift_next;
      saved_size    <= size_next;
      window_count  <= wc_next;
      tag_seen      <= tag_next;
      found_bitrate <= fbr_next;
    end
    if (file_stream.valid && file_stream.ready) begin
      s1.kind             <= file_stream.kind;
      s1.file_bytes_total <= file_stream.file_bytes_total;
      s1.data_byte        <= file_stream.data_byte;
      s1.last_byte        <= file_stream.last_byte;
    end
    if (fire && emit) begin
      out_verdict <= verdict_c;
      out_rate    <= rate_c;
      out_vbr     <= vbr_c;
    end
  end

  assign verdict_stream.valid        = out_valid;
  assign verdict_stream.verdict      = out_verdict;
  assign verdict_stream.bitrate_kbps = out_rate;
  assign verdict_stream.is_vbr       = out_vbr;

endmodule

@@ rtl/core/mp3sqc_checker.sv @@
`include "mp3_stream_quick_check_top_defines.svh"

module mp3sqc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [mp3sqc_pkg::VERDICT_W-1:0]   verdict,
  input logic [mp3sqc_pkg::RATE_W-1:0]      bitrate_kbps,
  input logic                               is_vbr
);

  logic reject_early;
  logic coherent;

  assign reject_early = (verdict == mp3sqc_pkg::VERDICT_TOO_LARGE) ||
                        (verdict == mp3sqc_pkg::VERDICT_TOO_SHORT) ||
                        (verdict == mp3sqc_pkg::VERDICT_BAD_HDR);
  assign coherent = (verdict != mp3sqc_pkg::VERDICT_LARGE_VBR || is_vbr) &&
                    (verdict != mp3sqc_pkg::VERDICT_LOW_RATE ||
                     (!is_vbr && bitrate_kbps != '0));

  `MP3SQC_ASSERT_NEXT_ON(rst_clears_a, clk, rst, !out_valid, "result pending after reset")
  `MP3SQC_ASSERT_NEXT(hold_a, clk, rst, out_valid && !out_ready, out_valid && $stable(verdict) && $stable(bitrate_kbps) && $stable(is_vbr), "stalled result changed")
  `MP3SQC_ASSERT_IMPL(early_reject_a, clk, rst, out_valid && reject_early, bitrate_kbps == '0 && !is_vbr, "early reject carries rate or vbr")
  `MP3SQC_ASSERT_IMPL(coherent_a, clk, rst, out_valid, coherent, "verdict inconsistent with rate or vbr flag")

endmodule

bind mp3_stream_quick_check_top mp3sqc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (verdict_stream.valid),
  .out_ready    (verdict_stream.ready),
  .verdict      (verdict_stream.verdict),
  .bitrate_kbps (verdict_stream.bitrate_kbps),
  .is_vbr       (verdict_stream.is_vbr)
);

@@ verif/mp3_stream_quick_check_verdict_checker.sv @@
`timescale 1ns / 100ps

module mp3_stream_quick_check_verdict_checker
  import mp3sqc_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mp3sqc_in_if                  file_mon,
  mp3sqc_out_if                 verdict_mon,
  output int unsigned           failures,
  output int unsigned           pending
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_PREFIX, PH_ID3, PH_HEADER, PH_WINDOW, PH_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [RATE_W-1:0]    bitrate_kbps;
    logic                 is_vbr;
  } verdict_t;

  localparam logic [SIZE_W-1:0] FILE_LIMIT_DEFAULT = 40'd52428800;
  localparam logic [SIZE_W-1:0] VBR_LIMIT_DEFAULT  = 40'd31457280;
  localparam logic [RATE_W-1:0] RATE_FLOOR_DEFAULT = 9'd64;

  localparam logic [1:0] VER_RESERVED   = 2'b01;
  localparam logic [1:0] VER_MPEG1      = 2'b11;
  localparam logic [1:0] LAYER_RESERVED = 2'b00;
  localparam logic [3:0] RATE_IDX_BAD   = 4'hF;
  localparam logic [1:0] SRATE_RESERVED = 2'b11;

  // [mpeg1 / mpeg2+2.5][layer I, II, III][bitrate index]
  localparam logic [RATE_W-1:0] KBPS [2][3][16] = '{
    '{
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
    },
    '{
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    }
  };

  logic [SIZE_W-1:0] lim_file;
  logic [SIZE_W-1:0] lim_vbr;
  logic [RATE_W-1:0] lim_rate;

  parse_phase_t      phase;
  logic [POS_W-1:0]  pos;
  logic [31:0]       hdr_start;
  logic [31:0]       last4;
  logic [SIZE_W-1:0] declared_len;
  int                win_cnt;
  logic              tag;
  logic [RATE_W-1:0] rate;

  verdict_t verdicts_due[$];

  function automatic logic frame_header_ok(logic [31:0] h);
    return ((h & SYNC_MASK) == SYNC_MASK) && (h[20:19] != VER_RESERVED) &&
           (h[18:17] != LAYER_RESERVED) && (h[15:12] != RATE_IDX_BAD) &&
           (h[11:10] != SRATE_RESERVED);
  endfunction

  function automatic logic [RATE_W-1:0] frame_bitrate(logic [31:0] h);
    if (h[18:17] == LAYER_RESERVED) return '0;
    return KBPS[(h[20:19] == VER_MPEG1) ? 0 : 1][3 - h[18:17]][h[15:12]];
  endfunction

  task automatic post_verdict(logic [VERDICT_W-1:0] v, logic [RATE_W-1:0] br, logic vbr);
    verdict_t e;
    e.verdict = v;
    e.bitrate_kbps = br;
    e.is_vbr = vbr;
    verdicts_due.push_back(e);
    phase = PH_DONE;
  endtask

  task automatic close_window();
    logic vbr;
    vbr = tag && (win_cnt >= VBR_MIN_WINDOW);
    if (vbr && declared_len > lim_vbr) post_verdict(VERDICT_LARGE_VBR, rate, 1'b1);
    else post_verdict(VERDICT_OK, rate, vbr);
  endtask

  task automatic take_item(logic kind, logic [SIZE_W-1:0] size, logic [BYTE_W-1:0] b,
                           logic last);
    logic [31:0] p;
    logic [27:0] tag_len;
    if (kind == KIND_START) begin
      declared_len = size;
      pos = '0;
      hdr_start = '0;
      last4 = '0;
      win_cnt = 0;
      tag = 1'b0;
      rate = '0;
      if (size > lim_file) post_verdict(VERDICT_TOO_LARGE, '0, 1'b0);
      else phase = PH_PREFIX;
      return;
    end
    if (phase == PH_IDLE || phase == PH_DONE) return;

    last4 = {last4[23:0], b};
    p = 32'(pos);
    if (pos != {POS_W{1'b1}}) pos++;

    case (phase)
      PH_PREFIX: begin
        if (p >= ID3_MAGIC_LAST) begin
          if (last4[23:0] == ID3_MAGIC) begin
            phase = PH_ID3;
          end else begin
            hdr_start = '0;
            phase = PH_HEADER;
          end
        end
      end
      PH_ID3: begin
        if (p >= ID3_SIZE_LAST) begin
          tag_len = {last4[30:24], last4[22:16], last4[14:8], last4[6:0]};
          hdr_start = 32'(tag_len) + ID3_HDR_BYTES;
          phase = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (p == hdr_start + FRAME_HDR_LAST) begin
          if (!frame_header_ok(last4)) begin
            post_verdict(VERDICT_BAD_HDR, '0, 1'b0);
            return;
          end
          rate = frame_bitrate(last4);
          if (rate != 0 && rate < lim_rate) begin
            post_verdict(VERDICT_LOW_RATE, rate, 1'b0);
            return;
          end
          phase = PH_WINDOW;
          if (last) close_window();
          return;
        end
      end
      PH_WINDOW: begin
        if (win_cnt >= TAG_LAST_OFF && (last4 == XING_MAGIC || last4 == INFO_MAGIC))
          tag = 1'b1;
        if (win_cnt == VBRI_LAST_OFF && last4 == VBRI_MAGIC) tag = 1'b1;
        win_cnt++;
        if (last || win_cnt >= WINDOW_BYTES) close_window();
        return;
      end
      default: ;
    endcase

    if (last) post_verdict(VERDICT_TOO_SHORT, '0, 1'b0);
  endtask

  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      lim_file = FILE_LIMIT_DEFAULT;
      lim_vbr = VBR_LIMIT_DEFAULT;
      lim_rate = RATE_FLOOR_DEFAULT;
      phase = PH_IDLE;
      pos = '0;
      hdr_start = '0;
      last4 = '0;
      declared_len = '0;
      win_cnt = 0;
      tag = 1'b0;
      rate = '0;
      verdicts_due.delete();
      failures = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAX_FILE: lim_file = cfg_data[SIZE_W-1:0];
          CFG_MAX_VBR:  lim_vbr = cfg_data[SIZE_W-1:0];
          CFG_MIN_RATE: lim_rate = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (file_mon.valid && file_mon.ready)
        take_item(file_mon.kind, file_mon.file_bytes_total, file_mon.data_byte,
                  file_mon.last_byte);
      if (verdict_mon.valid && verdict_mon.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected verdict item: verdict %0d bitrate_kbps %0d is_vbr %0d",
                 verdict_mon.verdict, verdict_mon.bitrate_kbps, verdict_mon.is_vbr);
          failures++;
        end else begin
          e = verdicts_due.pop_front();
          if (verdict_mon.verdict !== e.verdict) begin
            $error("verdict: expected %0d, got %0d", e.verdict, verdict_mon.verdict);
            failures++;
          end
          if (verdict_mon.bitrate_kbps !== e.bitrate_kbps) begin
            $error("bitrate_kbps: expected %0d, got %0d", e.bitrate_kbps,
                   verdict_mon.bitrate_kbps);
            failures++;
          end
          if (verdict_mon.is_vbr !== e.is_vbr) begin
            $error("is_vbr: expected %0d, got %0d", e.is_vbr, verdict_mon.is_vbr);
            failures++;
          end
        end
      end
    end
    pending = verdicts_due.size();
  end

endmodule

@@ verif/mp3_stream_quick_check_top_test.sv @@
`timescale 1ns / 100ps

module mp3_stream_quick_check_top_test;
  import mp3sqc_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mp3sqc_in_if  file_stream ();
  mp3sqc_out_if verdict_stream ();

  int unsigned failures;
  int unsigned pending;

  logic [SIZE_W-1:0] cur_max_file;
  logic [SIZE_W-1:0] cur_max_vbr;
  int                items_sent;
  int                results_taken;
  bit                send_burst;
  bit                take_burst;

  mp3_stream_quick_check_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .file_stream    (file_stream),
    .verdict_stream (verdict_stream)
  );

  mp3_stream_quick_check_verdict_checker verdict_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .file_mon    (file_stream),
    .verdict_mon (verdict_stream),
    .failures    (failures),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #1_000_000;
    $display("mp3_stream_quick_check_top_test NOT OK");
    $finish;
  end

  function automatic logic [SIZE_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SIZE_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    logic [63:0] span;
    logic [63:0] r;
    span = {24'd0, cur_max_file} + 64'd1;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return rand40();
      1: return cur_max_file + 1'b1;
      2: return cur_max_file;
      3: return (cur_max_vbr < cur_max_file) ? cur_max_vbr + 1'b1 : cur_max_file;
      4: return (cur_max_vbr <= cur_max_file) ? cur_max_vbr : cur_max_file;
      default: return SIZE_W'(r % span);
    endcase
  endfunction

  task automatic offer(logic kind, logic [SIZE_W-1:0] size, logic [BYTE_W-1:0] b,
                       logic last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      file_stream.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    file_stream.valid <= 1'b1;
    file_stream.kind <= kind;
    file_stream.file_bytes_total <= size;
    file_stream.data_byte <= b;
    file_stream.last_byte <= last;
    do @(posedge clk); while (!file_stream.ready);
    items_sent++;
  endtask

  task automatic send_start(logic [SIZE_W-1:0] size);
    offer(KIND_START, size, BYTE_W'($urandom), 1'($urandom));
  endtask

  // bytes past the final one carry a random last flag; they must be ignored
  task automatic send_bytes(input logic [BYTE_W-1:0] fb[$], input int last_at);
    for (int i = 0; i < fb.size(); i++)
      offer(KIND_BYTE, rand40(), fb[i],
            (i == last_at) || (last_at >= 0 && i > last_at && $urandom_range(0, 1) == 1));
  endtask

  task automatic send_random_file();
    logic [BYTE_W-1:0] fb[$];
    logic [31:0]       hdr;
    logic [31:0]       tw;
    logic [1:0]        ver;
    int                pad;
    int                wlen;
    int                ws;
    int                off;
    int                last_at;
    int                r;

    send_burst = ($urandom_range(0, 4) == 0);
    send_start(pick_size());

    r = $urandom_range(0, 9);
    if (r < 4) begin
      fb.push_back(ID3_MAGIC[23:16]);
      fb.push_back(ID3_MAGIC[15:8]);
      fb.push_back(ID3_MAGIC[7:0]);
      repeat (3) fb.push_back(BYTE_W'($urandom));
      if (r == 0) begin
        // arbitrary tag size, usually far beyond the end of the file
        repeat (4) fb.push_back(BYTE_W'($urandom));
      end else begin
        pad = $urandom_range(0, 24);
        repeat (3) fb.push_back({1'($urandom), 7'd0});
        fb.push_back({1'($urandom), 7'(pad)});
        repeat (pad) fb.push_back(BYTE_W'($urandom));
      end
    end else if (r == 4) begin
      fb.push_back(ID3_MAGIC[23:16]);
      fb.push_back(ID3_MAGIC[15:8]);
    end

    // frame header: each field sometimes drawn over its full range
    r = $urandom_range(0, 2);
    ver = 2'(r + (r != 0));
    hdr = {11'h7FF, ver, 2'($urandom_range(1, 3)), 1'($urandom),
           4'($urandom_range(0, 14)), 2'($urandom_range(0, 2)), 10'($urandom)};
    case ($urandom_range(0, 11))
      0: hdr = $urandom;
      1: hdr[21 + $urandom_range(0, 10)] = 1'b0;
      2: hdr[20:19] = 2'($urandom);
      3: hdr[18:17] = 2'($urandom);
      4: hdr[15:12] = 4'($urandom);
      5: hdr[11:10] = 2'($urandom);
      default: ;
    endcase
    for (int k = 0; k < 4; k++) fb.push_back(hdr[31 - 8 * k -: 8]);

    r = $urandom_range(0, 9);
    if (r == 0) wlen = 0;
    else if (r == 1) wlen = $urandom_range(195, 215);
    else wlen = $urandom_range(1, 60);
    ws = fb.size();
    repeat (wlen) fb.push_back(BYTE_W'($urandom));

    r = $urandom_range(0, 5);
    tw = (r == 1) ? INFO_MAGIC : (r < 1) ? XING_MAGIC : VBRI_MAGIC;
    off = -1;
    if (r <= 1 && wlen >= 4) off = $urandom_range(0, wlen - 4);
    else if (r == 2 && wlen >= 40) off = 36;
    else if (r == 3 && wlen >= 4) off = $urandom_range(0, wlen - 4);
    if (off >= 0)
      for (int k = 0; k < 4; k++) fb[ws + off + k] = tw[31 - 8 * k -: 8];

    last_at = fb.size() - 1;
    r = $urandom_range(0, 11);
    if (r == 0) begin
      last_at = $urandom_range(0, fb.size() - 1);
      fb = fb[0:last_at];
    end else if (r == 1) begin
      last_at = -1;
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) fb.push_back(BYTE_W'($urandom));

    send_bytes(fb, last_at);
  endtask

  task automatic settle_and_configure(logic [SIZE_W-1:0] mf, logic [SIZE_W-1:0] mv,
                                      logic [RATE_W-1:0] mr);
    file_stream.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAX_FILE;
    cfg_data <= CFG_DATA_W'(mf);
    @(posedge clk);
    cfg_index <= CFG_MAX_VBR;
    cfg_data <= CFG_DATA_W'(mv);
    @(posedge clk);
    cfg_index <= CFG_MIN_RATE;
    cfg_data <= CFG_DATA_W'(mr);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_max_file = mf;
    cur_max_vbr = mv;
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    bit held;
    int gap;
    held = 1'b0;
    take_burst = 1'b0;
    verdict_stream.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (results_taken == 3 && !held) begin
        held = 1'b1;
        verdict_stream.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      if (results_taken % 8 == 0) take_burst = ($urandom_range(0, 3) == 0);
      gap = take_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        verdict_stream.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      verdict_stream.ready <= 1'b1;
      do @(posedge clk); while (!verdict_stream.valid);
      results_taken++;
    end
  end

  initial begin
    logic [BYTE_W-1:0] fb[$];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_MAX_FILE;
    cfg_data = '0;
    file_stream.valid = 1'b0;
    file_stream.kind = KIND_START;
    file_stream.file_bytes_total = '0;
    file_stream.data_byte = '0;
    file_stream.last_byte = 1'b0;
    cur_max_file = 40'd52428800;
    cur_max_vbr = 40'd31457280;
    items_sent = 0;
    results_taken = 0;
    send_burst = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // byte before any file, oversize file, byte after its verdict
    offer(KIND_BYTE, rand40(), 8'h55, 1'b1);
    send_start({SIZE_W{1'b1}});
    offer(KIND_BYTE, rand40(), 8'hAA, 1'b0);
    // file ends on the header: accepted, 128 kbps, not vbr
    send_start('0);
    fb = '{8'hFF, 8'hFB, 8'h90, 8'h64};
    send_bytes(fb, 3);
    // ends inside the tag prefix
    send_start(40'd1000);
    fb = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00};
    send_bytes(fb, 4);
    // no sync
    send_start(40'd5);
    fb = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(fb, 3);
    // mpeg2 layer III at 8 kbps
    send_start(40'd50);
    fb = '{8'hFF, 8'hF3, 8'h10, 8'h00};
    send_bytes(fb, 3);

    while (items_sent < 375) send_random_file();
    settle_and_configure({SIZE_W{1'b1}}, '0, '0);
    while (items_sent < 725) send_random_file();
    settle_and_configure('0, {SIZE_W{1'b1}}, 9'd448);
    while (items_sent < 1075) send_random_file();
    settle_and_configure(rand40(), rand40(), RATE_W'($urandom_range(0, 448)));
    while (items_sent < 1425) send_random_file();
    settle_and_configure(40'd52428800, 40'd31457280, 9'd64);
    while (items_sent < 1775) send_random_file();

    file_stream.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("mp3_stream_quick_check_top_test OK");
    end else begin
      $display("mp3_stream_quick_check_top_test NOT OK");
    end
    $finish;
  end

endmodule
